### hw/rtl/shg_pkg.sv
package shg_pkg;

  // command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_JUDGE  = 1'b1;

  // swing directions
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // outcome codes
  localparam logic [1:0] OUT_INCONCLUSIVE = 2'd0;
  localparam logic [1:0] OUT_PERFECT      = 2'd1;
  localparam logic [1:0] OUT_DECENT       = 2'd2;
  localparam logic [1:0] OUT_MISSED       = 2'd3;

  // register indexes
  localparam logic [2:0] REG_START_TIME = 3'd0;
  localparam logic [2:0] REG_PUSH_THR   = 3'd1;
  localparam logic [2:0] REG_PULL_THR   = 3'd2;
  localparam logic [2:0] REG_PUSH_HOLD  = 3'd3;
  localparam logic [2:0] REG_PULL_HOLD  = 3'd4;
  localparam logic [2:0] REG_EARLY_WIN  = 3'd5;
  localparam logic [2:0] REG_LATE_WIN   = 3'd6;

  // register reset values
  localparam logic [31:0] RST_START_TIME = 32'd0;
  localparam logic [14:0] RST_PUSH_THR   = 15'd3840;
  localparam logic [14:0] RST_PULL_THR   = 15'd3072;
  localparam logic [4:0]  RST_PUSH_HOLD  = 5'd7;
  localparam logic [4:0]  RST_PULL_HOLD  = 5'd5;
  localparam logic [15:0] RST_EARLY_WIN  = 16'd100;
  localparam logic [15:0] RST_LATE_WIN   = 16'd140;

  // grading limits, ms
  localparam logic [31:0] PERFECT_DIFF_MS = 32'd70;
  localparam logic [31:0] DECENT_DIFF_MS  = 32'd120;

  // swing detector phases
  localparam logic [1:0] PH_SEEK = 2'd0;
  localparam logic [1:0] PH_PUSH = 2'd1;
  localparam logic [1:0] PH_ARM  = 2'd2;
  localparam logic [1:0] PH_PULL = 2'd3;

  typedef struct packed {
    logic clear;
    logic step;
  } det_ctrl_t;

endpackage

### hw/rtl/shg_ram.sv
module shg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/shg_swing_det.sv
module shg_swing_det import shg_pkg::*; #(
  parameter int PW = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  det_ctrl_t           ctrl_i,
  input  logic signed [16:0]  sample_i,
  input  logic [PW-1:0]       pos_i,
  input  logic [14:0]         push_thr_i,
  input  logic [14:0]         pull_thr_i,
  input  logic [4:0]          push_hold_i,
  input  logic [4:0]          pull_hold_i,
  output logic                found_o,
  output logic [PW-1:0]       pull_at_o
);

  localparam int DW = (PW > 5) ? PW : 5;

  logic [1:0]         phase_q, phase_d;
  logic               found_q, found_d;
  logic [PW-1:0]      push_at_q, push_at_d;
  logic [PW-1:0]      pull_at_q, pull_at_d;
  logic signed [16:0] push_lim;
  logic signed [16:0] pull_lim;
  logic [DW-1:0]      push_len;
  logic [DW-1:0]      pull_len;

  assign push_lim = $signed({2'b00, push_thr_i});
  assign pull_lim = -$signed({2'b00, pull_thr_i});
  assign push_len = DW'(pos_i) - DW'(push_at_q);
  assign pull_len = DW'(pos_i) - DW'(pull_at_q);

  always_comb begin
    phase_d   = phase_q;
    found_d   = found_q;
    push_at_d = push_at_q;
    pull_at_d = pull_at_q;
    if (ctrl_i.clear) begin
      phase_d = PH_SEEK;
      found_d = 1'b0;
    end else if (ctrl_i.step && !found_q) begin
      case (phase_q)
        PH_SEEK: begin
          if (sample_i >= push_lim) begin
            phase_d   = PH_PUSH;
            push_at_d = pos_i;
          end
        end
        PH_PUSH: begin
          if (sample_i < push_lim) begin
            phase_d = PH_SEEK;
          end else if (push_len >= DW'(push_hold_i)) begin
            phase_d = PH_ARM;
          end
        end
        PH_ARM: begin
          if (sample_i <= pull_lim) begin
            phase_d   = PH_PULL;
            pull_at_d = pos_i;
          end
        end
        PH_PULL: begin
          if (sample_i > pull_lim) begin
            phase_d = PH_ARM;
          end else if (pull_len >= DW'(pull_hold_i)) begin
            found_d = 1'b1;
          end
        end
        default: phase_d = PH_SEEK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEEK;
      found_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    push_at_q <= push_at_d;
    pull_at_q <= pull_at_d;
  end

  assign found_o   = found_q;
  assign pull_at_o = pull_at_q;

endmodule

### hw/rtl/swing_gesture_hit_judge.sv
// Swing gesture hit judge. A sample request (command 0) stores one x/z
// acceleration pair (signed Q8.8) in a ring history of HISTORY_DEPTH entries
// and returns its result once the output register is free. A judge request
// (command 1) checks the early and late windows, then scans the history
// oldest to newest, one entry per cycle through the single history RAM read
// port and a shared swing detector, and grades the onset of the reverse
// pull. A judge ends before the scan is through when the swing completes
// early in it, and without a scan when the window check decides it. The
// next request is taken the cycle after a result is loaded. One request
// is in work at a time; a finished result waits in the output register
// while the next request is taken, and the next result waits until that
// register is free.
// sensor_stuck is kept by a run-length counter, so it costs no scan.
// Configuration writes are always ready and must only be issued while the
// block is idle.
module swing_gesture_hit_judge import shg_pkg::*; #(
  parameter int HISTORY_DEPTH    = 32,
  parameter int SAMPLE_PERIOD_MS = 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_z_i,
  input  logic [1:0]  direction_i,
  input  logic [31:0] note_time_ms_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  outcome_o,
  output logic        sensor_stuck_o
);

  localparam int PW = $clog2(HISTORY_DEPTH);
  localparam int RW = $clog2(HISTORY_DEPTH + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXP   = 3'd1;
  localparam logic [2:0] ST_EARLY = 3'd2;
  localparam logic [2:0] ST_LATE  = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_HIT   = 3'd5;
  localparam logic [2:0] ST_GRADE = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  // configuration
  logic [31:0] start_q;
  logic [14:0] push_thr_q;
  logic [14:0] pull_thr_q;
  logic [4:0]  push_hold_q;
  logic [4:0]  pull_hold_q;
  logic [15:0] early_q;
  logic [15:0] late_q;
  logic        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= RST_START_TIME;
      push_thr_q  <= RST_PUSH_THR;
      pull_thr_q  <= RST_PULL_THR;
      push_hold_q <= RST_PUSH_HOLD;
      pull_hold_q <= RST_PULL_HOLD;
      early_q     <= RST_EARLY_WIN;
      late_q      <= RST_LATE_WIN;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_START_TIME: start_q     <= cfg_data_i;
        REG_PUSH_THR:   push_thr_q  <= cfg_data_i[14:0];
        REG_PULL_THR:   pull_thr_q  <= cfg_data_i[14:0];
        REG_PUSH_HOLD:  push_hold_q <= cfg_data_i[4:0];
        REG_PULL_HOLD:  pull_hold_q <= cfg_data_i[4:0];
        REG_EARLY_WIN:  early_q     <= cfg_data_i[15:0];
        REG_LATE_WIN:   late_q      <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  logic [2:0]         state_q, state_d;
  logic [PW-1:0]      wp_q, wp_d;
  logic [RW-1:0]      run_q, run_d;
  logic signed [15:0] last_x_q, last_x_d;
  logic signed [15:0] last_z_q, last_z_d;
  logic [HISTORY_DEPTH-1:0] valid_q, valid_d;
  logic [PW:0]        rd_cnt_q, rd_cnt_d;
  logic               data_vld_q, data_vld_d;
  logic [PW-1:0]      data_pos_q, data_pos_d;
  logic               ent_vld_q;
  logic [1:0]         dir_q, dir_d;
  logic [31:0]        note_q, note_d;
  logic [31:0]        now_q, now_d;
  logic [31:0]        exp_q, exp_d;
  logic [31:0]        hit_q, hit_d;
  logic [1:0]         outcome_q, outcome_d;
  logic               out_valid_q, out_valid_d;
  logic [1:0]         out_outcome_q, out_outcome_d;
  logic               out_stuck_q, out_stuck_d;

  logic               in_acc;
  logic               ram_we;
  logic [PW-1:0]      rd_addr;
  logic [PW:0]        addr_sum;
  logic [31:0]        ram_rdata;
  logic signed [16:0] ent_x;
  logic signed [16:0] ent_z;
  logic signed [16:0] ent_sel;
  logic signed [16:0] sample;
  logic               use_z;
  logic               pos_first;
  det_ctrl_t          det_ctrl;
  logic               det_found;
  logic [PW-1:0]      det_pull_at;
  logic [PW-1:0]      back_idx;
  logic [31:0]        back_ms;
  logic               hit_le_exp;
  logic [31:0]        diff_ms;
  logic               stuck;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign ram_we     = in_acc & (command_i == CMD_SAMPLE);
  assign stuck      = (run_q == RW'(HISTORY_DEPTH));

  assign addr_sum = {1'b0, wp_q} + {1'b0, rd_cnt_q[PW-1:0]};
  assign rd_addr  = (addr_sum >= (PW+1)'(HISTORY_DEPTH)) ?
                    PW'(addr_sum - (PW+1)'(HISTORY_DEPTH)) : PW'(addr_sum);

  shg_ram #(
    .WIDTH (32),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i ({accel_x_i, accel_z_i}),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // entries never written read as zero
  assign ent_x     = ent_vld_q ? 17'($signed(ram_rdata[31:16])) : 17'sd0;
  assign ent_z     = ent_vld_q ? 17'($signed(ram_rdata[15:0]))  : 17'sd0;
  assign use_z     = (dir_q == DIR_UP) || (dir_q == DIR_DOWN);
  assign pos_first = (dir_q == DIR_UP) || (dir_q == DIR_RIGHT);
  assign ent_sel   = use_z ? ent_z : ent_x;
  assign sample    = pos_first ? ent_sel : -ent_sel;

  assign det_ctrl.clear = (state_q == ST_LATE);
  assign det_ctrl.step  = (state_q == ST_SCAN) && data_vld_q;

  shg_swing_det #(
    .PW (PW)
  ) u_det (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (det_ctrl),
    .sample_i    (sample),
    .pos_i       (data_pos_q),
    .push_thr_i  (push_thr_q),
    .pull_thr_i  (pull_thr_q),
    .push_hold_i (push_hold_q),
    .pull_hold_i (pull_hold_q),
    .found_o     (det_found),
    .pull_at_o   (det_pull_at)
  );

  assign back_idx   = PW'(HISTORY_DEPTH - 1) - det_pull_at;
  assign back_ms    = 32'(SAMPLE_PERIOD_MS) * 32'(back_idx);
  assign hit_le_exp = (exp_q >= hit_q);
  assign diff_ms    = hit_le_exp ? (exp_q - hit_q) : (hit_q - exp_q);

  always_comb begin
    state_d       = state_q;
    wp_d          = wp_q;
    run_d         = run_q;
    last_x_d      = last_x_q;
    last_z_d      = last_z_q;
    valid_d       = valid_q;
    rd_cnt_d      = rd_cnt_q;
    data_vld_d    = 1'b0;
    data_pos_d    = data_pos_q;
    dir_d         = dir_q;
    note_d        = note_q;
    now_d         = now_q;
    exp_d         = exp_q;
    hit_d         = hit_q;
    outcome_d     = outcome_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    out_outcome_d = out_outcome_q;
    out_stuck_d   = out_stuck_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          dir_d  = direction_i;
          note_d = note_time_ms_i;
          now_d  = now_ms_i;
          if (command_i == CMD_SAMPLE) begin
            valid_d[wp_q] = 1'b1;
            wp_d          = (wp_q == PW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
            last_x_d      = accel_x_i;
            last_z_d      = accel_z_i;
            if (accel_x_i == last_x_q && accel_z_i == last_z_q) begin
              run_d = stuck ? run_q : run_q + 1'b1;
            end else begin
              run_d = RW'(1);
            end
            outcome_d = OUT_INCONCLUSIVE;
            state_d   = ST_DONE;
          end else begin
            state_d = ST_EXP;
          end
        end
      end
      ST_EXP: begin
        exp_d   = start_q + note_q;
        state_d = ST_EARLY;
      end
      ST_EARLY: begin
        if (exp_q > now_q + {16'd0, early_q}) begin
          outcome_d = OUT_INCONCLUSIVE;
          state_d   = ST_DONE;
        end else begin
          state_d = ST_LATE;
        end
      end
      ST_LATE: begin
        rd_cnt_d = '0;
        if (now_q > exp_q + {16'd0, late_q}) begin
          outcome_d = OUT_MISSED;
          state_d   = ST_DONE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_cnt_q < (PW+1)'(HISTORY_DEPTH)) begin
          data_vld_d = 1'b1;
          data_pos_d = rd_cnt_q[PW-1:0];
          rd_cnt_d   = rd_cnt_q + 1'b1;
        end
        if (det_found) begin
          state_d = ST_HIT;
        end else if (!data_vld_q && rd_cnt_q == (PW+1)'(HISTORY_DEPTH)) begin
          outcome_d = OUT_INCONCLUSIVE;
          state_d   = ST_DONE;
        end
      end
      ST_HIT: begin
        hit_d   = now_q - back_ms;
        state_d = ST_GRADE;
      end
      ST_GRADE: begin
        if (diff_ms <= PERFECT_DIFF_MS) begin
          outcome_d = OUT_PERFECT;
        end else if (hit_le_exp) begin
          outcome_d = OUT_INCONCLUSIVE;
        end else if (diff_ms <= DECENT_DIFF_MS) begin
          outcome_d = OUT_DECENT;
        end else begin
          outcome_d = OUT_MISSED;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          out_outcome_d = outcome_q;
          out_stuck_d   = stuck;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      run_q       <= RW'(HISTORY_DEPTH);
      last_x_q    <= '0;
      last_z_q    <= '0;
      valid_q     <= '0;
      rd_cnt_q    <= '0;
      data_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      run_q       <= run_d;
      last_x_q    <= last_x_d;
      last_z_q    <= last_z_d;
      valid_q     <= valid_d;
      rd_cnt_q    <= rd_cnt_d;
      data_vld_q  <= data_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_vld_q     <= valid_q[rd_addr];
    data_pos_q    <= data_pos_d;
    dir_q         <= dir_d;
    note_q        <= note_d;
    now_q         <= now_d;
    exp_q         <= exp_d;
    hit_q         <= hit_d;
    outcome_q     <= outcome_d;
    out_outcome_q <= out_outcome_d;
    out_stuck_q   <= out_stuck_d;
  end

  assign out_valid_o    = out_valid_q;
  assign outcome_o      = out_outcome_q;
  assign sensor_stuck_o = out_stuck_q;

endmodule

### sim/swing_gesture_hit_judge_test.sv
`timescale 1ns / 1ps

module swing_gesture_hit_judge_test;
  import shg_pkg::*;

  localparam int HIST_DEPTH = 32;
  localparam int SAMPLE_MS = 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 75;
  localparam int PHASES = 8;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [2:0] REG_SPARE = 3'd7;

  typedef enum int {REGS_TYPICAL, REGS_HIGH, REGS_LOW} reg_mix_e;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] ax;
    logic signed [15:0] az;
    logic [1:0]         dir;
    logic [31:0]        note;
    logic [31:0]        now;
  } swing_req_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic       stuck;
  } judge_res_t;

  typedef struct {
    swing_req_t req;
    bit         typed;
    judge_res_t want;
  } script_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        command_i = CMD_SAMPLE;
  logic signed [15:0] accel_x_i = '0;
  logic signed [15:0] accel_z_i = '0;
  logic [1:0]  direction_i = DIR_UP;
  logic [31:0] note_time_ms_i = '0;
  logic [31:0] now_ms_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  outcome_o;
  logic        sensor_stuck_o;

  swing_gesture_hit_judge #(
    .HISTORY_DEPTH   (HIST_DEPTH),
    .SAMPLE_PERIOD_MS(SAMPLE_MS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .accel_x_i     (accel_x_i),
    .accel_z_i     (accel_z_i),
    .direction_i   (direction_i),
    .note_time_ms_i(note_time_ms_i),
    .now_ms_i      (now_ms_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .outcome_o     (outcome_o),
    .sensor_stuck_o(sensor_stuck_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // judge state mirror
  logic signed [15:0] hist_x [HIST_DEPTH];
  logic signed [15:0] hist_z [HIST_DEPTH];
  int          wr_ptr;
  logic [31:0] song_start;
  int          push_thr, pull_thr, push_hold, pull_hold;
  logic [31:0] early_win, late_win;

  judge_res_t  verdicts_due[$];
  script_row_t script[$];
  logic [31:0] reg_plan [8];
  int          mismatches = 0;
  int          offered = 0;
  int          cycles = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          rx_hold_left = 0;

  function automatic void clear_mirror();
    for (int i = 0; i < HIST_DEPTH; i++) begin
      hist_x[i] = '0;
      hist_z[i] = '0;
    end
    wr_ptr = 0;
    song_start = RST_START_TIME;
    push_thr = int'(RST_PUSH_THR);
    pull_thr = int'(RST_PULL_THR);
    push_hold = int'(RST_PUSH_HOLD);
    pull_hold = int'(RST_PULL_HOLD);
    early_win = 32'(RST_EARLY_WIN);
    late_win = 32'(RST_LATE_WIN);
  endfunction

  function automatic logic [1:0] grade_onset(logic [31:0] due, logic [31:0] hit);
    logic [31:0] gap;
    if (due >= hit) begin
      gap = due - hit;
      return (gap <= PERFECT_DIFF_MS) ? OUT_PERFECT : OUT_INCONCLUSIVE;
    end
    gap = hit - due;
    if (gap <= PERFECT_DIFF_MS) return OUT_PERFECT;
    if (gap <= DECENT_DIFF_MS) return OUT_DECENT;
    return OUT_MISSED;
  endfunction

  function automatic logic [1:0] judge_swing(logic [1:0] dir, logic [31:0] note,
                                             logic [31:0] now);
    logic [31:0] due, early_edge, late_edge, back;
    logic        use_z, pos_first;
    logic [1:0]  phase;
    int          a, idx, push_at, pull_at;
    due = song_start + note;
    early_edge = now + early_win;
    late_edge = due + late_win;
    if (due > early_edge) return OUT_INCONCLUSIVE;
    if (now > late_edge) return OUT_MISSED;
    use_z = (dir == DIR_UP) || (dir == DIR_DOWN);
    pos_first = (dir == DIR_UP) || (dir == DIR_RIGHT);
    phase = PH_SEEK;
    push_at = 0;
    pull_at = 0;
    for (int p = 0; p < HIST_DEPTH; p++) begin
      idx = (wr_ptr + p) % HIST_DEPTH;
      a = use_z ? int'(hist_z[idx]) : int'(hist_x[idx]);
      if (!pos_first) a = -a;
      case (phase)
        PH_SEEK: if (a >= push_thr) begin
          phase = PH_PUSH;
          push_at = p;
        end
        PH_PUSH: if (a < push_thr) begin
          phase = PH_SEEK;
        end else if (p - push_at >= push_hold) begin
          phase = PH_ARM;
        end
        PH_ARM: if (a <= -pull_thr) begin
          phase = PH_PULL;
          pull_at = p;
        end
        default: if (a > -pull_thr) begin
          phase = PH_ARM;
        end else if (p - pull_at >= pull_hold) begin
          back = 32'(SAMPLE_MS * (HIST_DEPTH - 1 - pull_at));
          return grade_onset(due, now - back);
        end
      endcase
    end
    return OUT_INCONCLUSIVE;
  endfunction

  function automatic judge_res_t rule_on(swing_req_t r);
    judge_res_t v;
    bit         flat;
    v.outcome = OUT_INCONCLUSIVE;
    if (r.cmd == CMD_SAMPLE) begin
      hist_x[wr_ptr] = r.ax;
      hist_z[wr_ptr] = r.az;
      wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
    end else begin
      v.outcome = judge_swing(r.dir, r.note, r.now);
    end
    flat = 1'b1;
    for (int i = 0; i + 1 < HIST_DEPTH; i++) begin
      if (hist_x[i] != hist_x[i + 1] || hist_z[i] != hist_z[i + 1]) flat = 1'b0;
    end
    v.stuck = flat;
    return v;
  endfunction

  function automatic swing_req_t mk_req(logic cmd, logic [15:0] ax, logic [15:0] az,
                                        logic [1:0] dir, logic [31:0] note,
                                        logic [31:0] now);
    swing_req_t r;
    r.cmd = cmd;
    r.ax = ax;
    r.az = az;
    r.dir = dir;
    r.note = note;
    r.now = now;
    return r;
  endfunction

  task automatic add_row(logic cmd, logic [15:0] ax, logic [15:0] az, logic [1:0] dir,
                         logic [31:0] note, logic [31:0] now, bit typed,
                         logic [1:0] outcome, logic stuck);
    script_row_t row;
    row.req = mk_req(cmd, ax, az, dir, note, now);
    row.typed = typed;
    row.want.outcome = outcome;
    row.want.stuck = stuck;
    script.push_back(row);
  endtask

  task automatic offer(swing_req_t r, bit typed, judge_res_t want);
    judge_res_t got;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= r.cmd;
    accel_x_i <= r.ax;
    accel_z_i <= r.az;
    direction_i <= r.dir;
    note_time_ms_i <= r.note;
    now_ms_i <= r.now;
    do @(posedge clk_i); while (!in_ready_o);
    got = rule_on(r);
    verdicts_due.push_back(typed ? want : got);
    offered++;
  endtask

  task automatic send_sample(logic [15:0] x, logic [15:0] z);
    offer(mk_req(CMD_SAMPLE, x, z, 2'($urandom), $urandom, $urandom), 1'b0, '0);
  endtask

  task automatic send_judge(logic [1:0] dir);
    int          d;
    logic [31:0] now;
    now = $urandom;
    if ($urandom_range(0, 1)) begin
      d = int'($urandom_range(0, 300)) - 150;
    end else begin
      d = int'($urandom_range(0, early_win + late_win + 40)) - int'(early_win) - 20;
    end
    offer(mk_req(CMD_JUDGE, 16'($urandom), 16'($urandom), dir,
                 now - 32'(d) - song_start, now), 1'b0, '0);
  endtask

  // lead-in noise, push, neutral gap, pull, tail, then one or two judges
  task automatic swing_burst();
    logic [1:0] dir;
    bit         use_z;
    int         sense, push_len, pull_len, m;
    dir = 2'($urandom);
    use_z = (dir == DIR_UP) || (dir == DIR_DOWN);
    sense = ((dir == DIR_UP) || (dir == DIR_RIGHT)) ? 1 : -1;
    repeat ($urandom_range(0, 3)) send_sample(16'($urandom), 16'($urandom));
    push_len = push_hold + 1 + int'($urandom_range(0, 2));
    if ($urandom_range(0, 9) == 0) push_len = push_hold;
    repeat (push_len) begin
      m = int'($urandom_range(push_thr, 32767));
      if (use_z) send_sample(16'($urandom), 16'(sense * m));
      else send_sample(16'(sense * m), 16'($urandom));
    end
    repeat ($urandom_range(0, 2)) send_sample('0, '0);
    pull_len = pull_hold + 1 + int'($urandom_range(0, 2));
    if ($urandom_range(0, 9) == 0) pull_len = pull_hold;
    repeat (pull_len) begin
      m = int'($urandom_range(pull_thr, 32767));
      if (use_z) send_sample(16'($urandom), 16'(-sense * m));
      else send_sample(16'(-sense * m), 16'($urandom));
    end
    repeat ($urandom_range(0, 2)) send_sample(16'($urandom), 16'($urandom));
    repeat ($urandom_range(1, 2)) begin
      send_judge(($urandom_range(0, 4) == 0) ? 2'($urandom) : dir);
    end
  endtask

  task automatic flat_burst();
    logic [15:0] x, z;
    x = 16'($urandom);
    z = 16'($urandom);
    repeat (HIST_DEPTH + int'($urandom_range(0, 2))) send_sample(x, z);
    send_judge(2'($urandom));
  endtask

  task automatic random_chunk();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      swing_burst();
    end else if (pick < 76) begin
      flat_burst();
    end else begin
      offer(mk_req(1'($urandom), 16'($urandom), 16'($urandom), 2'($urandom), $urandom,
                   $urandom), 1'b0, '0);
    end
  endtask

  task automatic set_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_START_TIME: song_start = data;
      REG_PUSH_THR:   push_thr = int'(data[14:0]);
      REG_PULL_THR:   pull_thr = int'(data[14:0]);
      REG_PUSH_HOLD:  push_hold = int'(data[4:0]);
      REG_PULL_HOLD:  pull_hold = int'(data[4:0]);
      REG_EARLY_WIN:  early_win = 32'(data[15:0]);
      REG_LATE_WIN:   late_win = 32'(data[15:0]);
      default: ;
    endcase
  endtask

  task automatic program_regs(reg_mix_e mix, bit poke_spare);
    case (mix)
      REGS_HIGH: begin
        for (int i = REG_START_TIME; i <= REG_LATE_WIN; i++) reg_plan[i] = 32'hFFFF_FFFF;
      end
      REGS_LOW: begin
        reg_plan[REG_START_TIME] = '0;
        reg_plan[REG_PUSH_THR] = $urandom & 32'hFFFF_8000;
        reg_plan[REG_PULL_THR] = $urandom & 32'hFFFF_8000;
        reg_plan[REG_PUSH_HOLD] = $urandom & 32'hFFFF_FFE0;
        reg_plan[REG_PULL_HOLD] = $urandom & 32'hFFFF_FFE0;
        reg_plan[REG_EARLY_WIN] = $urandom & 32'hFFFF_0000;
        reg_plan[REG_LATE_WIN] = $urandom & 32'hFFFF_0000;
      end
      default: begin
        reg_plan[REG_START_TIME] = $urandom;
        reg_plan[REG_PUSH_THR] = ($urandom & 32'hFFFF_8000) | $urandom_range(256, 6000);
        reg_plan[REG_PULL_THR] = ($urandom & 32'hFFFF_8000) | $urandom_range(256, 6000);
        reg_plan[REG_PUSH_HOLD] = ($urandom & 32'hFFFF_FFE0) | $urandom_range(0, 6);
        reg_plan[REG_PULL_HOLD] = ($urandom & 32'hFFFF_FFE0) | $urandom_range(0, 6);
        reg_plan[REG_EARLY_WIN] = ($urandom & 32'hFFFF_0000) | $urandom_range(0, 300);
        reg_plan[REG_LATE_WIN] = ($urandom & 32'hFFFF_0000) | $urandom_range(0, 300);
      end
    endcase
    for (int i = REG_START_TIME; i <= REG_LATE_WIN; i++) set_reg(3'(i), reg_plan[i]);
    if (poke_spare) set_reg(REG_SPARE, $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (verdicts_due.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("swing_gesture_hit_judge_test: done, errors");
      $finish;
    end
  end

  // result check and receiver stalls
  always @(posedge clk_i) begin
    judge_res_t want;
    if (out_valid_o && out_ready_i) begin
      if (verdicts_due.size() == 0) begin
        $error("unexpected result: outcome %0d, sensor_stuck %0d", outcome_o, sensor_stuck_o);
        mismatches++;
      end else begin
        want = verdicts_due.pop_front();
        if (outcome_o !== want.outcome) begin
          $error("outcome: expected %0d, actual %0d", want.outcome, outcome_o);
          mismatches++;
        end
        if (sensor_stuck_o !== want.stuck) begin
          $error("sensor_stuck: expected %0d, actual %0d", want.stuck, sensor_stuck_o);
          mismatches++;
        end
      end
    end
    if (rx_hold_left > 0) begin
      out_ready_i <= 1'b0;
      rx_hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  initial begin
    clear_mirror();
    // zeroed history, window edges, extreme samples, then an up swing
    add_row(CMD_JUDGE, '0, '0, DIR_UP, 32'd0, 32'd0, 1'b1, OUT_INCONCLUSIVE, 1'b1);
    add_row(CMD_JUDGE, '0, '0, DIR_DOWN, 32'd1000, 32'd0, 1'b1, OUT_INCONCLUSIVE, 1'b1);
    add_row(CMD_JUDGE, '0, '0, DIR_LEFT, 32'd0, 32'd1000, 1'b1, OUT_MISSED, 1'b1);
    add_row(CMD_SAMPLE, 16'h7FFF, 16'h8000, DIR_RIGHT, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            1'b1, OUT_INCONCLUSIVE, 1'b0);
    add_row(CMD_SAMPLE, 16'h8000, 16'h7FFF, DIR_UP, '0, '0, 1'b1, OUT_INCONCLUSIVE, 1'b0);
    repeat (7) add_row(CMD_SAMPLE, '0, 16'd4000, DIR_UP, '0, '0, 1'b0, '0, 1'b0);
    repeat (6) add_row(CMD_SAMPLE, '0, -16'sd4000, DIR_UP, '0, '0, 1'b0, '0, 1'b0);
    add_row(CMD_JUDGE, '0, '0, DIR_UP, 32'd9995, 32'd10000, 1'b0, '0, 1'b0);
    add_row(CMD_JUDGE, '0, '0, DIR_UP, 32'd9900, 32'd10000, 1'b0, '0, 1'b0);
    add_row(CMD_JUDGE, '0, '0, DIR_UP, 32'd9870, 32'd10000, 1'b0, '0, 1'b0);
    add_row(CMD_JUDGE, '0, '0, DIR_UP, 32'd10090, 32'd10000, 1'b0, '0, 1'b0);
    add_row(CMD_JUDGE, '0, '0, DIR_DOWN, 32'd9995, 32'd10000, 1'b0, '0, 1'b0);
    add_row(CMD_JUDGE, '0, '0, DIR_LEFT, 32'd9995, 32'd10000, 1'b0, '0, 1'b0);
    add_row(CMD_JUDGE, '0, '0, DIR_RIGHT, 32'd9995, 32'd10000, 1'b0, '0, 1'b0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) offer(script[i].req, script[i].typed, script[i].want);
    in_valid_i <= 1'b0;
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: program_regs(REGS_TYPICAL, 1'b0);
        2: program_regs(REGS_HIGH, 1'b0);
        3: program_regs(REGS_LOW, 1'b1);
        4: program_regs(REGS_TYPICAL, 1'b0);
        5: program_regs(REGS_TYPICAL, 1'b1);
        6: program_regs(REGS_LOW, 1'b0);
        7: program_regs(REGS_TYPICAL, 1'b1);
        default: ;
      endcase
      case (ph % 4)
        1: begin
          tx_idle_pct = 82;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 82;
        end
        3: begin
          tx_idle_pct = 19;
          rx_stall_pct = 19;
        end
        default: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
      endcase
      // long receiver hold-off: input side must back up
      if (ph == 4) rx_hold_left = 400;
      offered = 0;
      while (offered < PHASE_ITEMS) random_chunk();
      in_valid_i <= 1'b0;
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("swing_gesture_hit_judge_test: done, clean");
    end else begin
      $display("swing_gesture_hit_judge_test: done, errors");
    end
    $finish;
  end

endmodule
